[sv/tbthc_pkg.sv]
// Shared types and constants for the two-button tap/hold classifier.
package tbthc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned CODE_W = 8;
    localparam int unsigned IN_DATA_W = 56;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned NUM_KEYS = 5;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VERY_LONG = 2'd2;

    localparam logic [LIMIT_W-1:0] DEBOUNCE_RESET = 16'd25;
    localparam logic [LIMIT_W-1:0] HOLD_RESET = 16'd500;
    localparam logic [LIMIT_W-1:0] VERY_LONG_RESET = 16'd3000;

    localparam logic [CODE_W-1:0] GEST_NONE = 8'h00;
    localparam logic [CODE_W-1:0] GEST_UP = 8'h01;
    localparam logic [CODE_W-1:0] GEST_DOWN = 8'h02;
    localparam logic [CODE_W-1:0] GEST_RIGHT = 8'h04;
    localparam logic [CODE_W-1:0] GEST_TAP = 8'h05;

    // Button slots
    localparam int unsigned BTN_TOP = 0;
    localparam int unsigned BTN_BOTTOM = 1;

    typedef struct packed {
        logic [CODE_W-1:0] finger_count;
        logic [CODE_W-1:0] gesture_code;
        logic              touch_ok;
        logic              bottom_level;
        logic              top_level;
        logic [TIME_W-1:0] now_ms;
    } poll_t;

    typedef struct packed {
        logic any_change;
        logic power_off;
        logic key_back;
        logic key_select;
        logic key_down;
        logic key_up;
    } keys_t;

endpackage

[sv/two_button_tap_hold_classifier.sv]
// Top level of the two-button tap/hold key classifier.
// One result per poll. A poll is taken into an input register, classified by a
// 32-bit wrap-around subtract, a debounce and a hold compare per button, a very-long
// compare on the bottom button and the gesture decode, and the key flags land in an
// output register; a new poll is accepted every cycle while the output side keeps
// taking results. The limits are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while no poll is in flight, as the block does not enforce it;
// writes to an index beyond the three limits are ignored.
module two_button_tap_hold_classifier
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [tbthc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tbthc_pkg::LIMIT_W-1:0]          cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [31:0] now_ms, [32] top_level, [33] bottom_level,
    // [41:34] gesture_code, [49:42] finger_count, [55:50] zero
    input  logic [tbthc_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // [0] touch_ok
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [0] key_up, [1] key_down, [2] key_select, [3] key_back,
    // [4] power_off, [5] any_change, [7:6] zero
    output logic [tbthc_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
    import tbthc_pkg::*;

    logic [LIMIT_W-1:0] debounce_reg;
    logic [LIMIT_W-1:0] hold_reg;
    logic [LIMIT_W-1:0] very_long_reg;

    logic               in_valid_reg;
    poll_t              in_item_reg;
    logic               out_valid_reg;
    keys_t              out_keys_reg;

    logic [1:0]         level_reg;
    logic [1:0]         level_next;
    logic [TIME_W-1:0]  press_time_reg [2];
    logic [TIME_W-1:0]  press_time_next [2];
    logic               latch_reg;
    logic               latch_next;

    logic               advance;
    logic               commit;
    logic [1:0]         cur_level;
    logic [1:0]         released;
    logic [TIME_W-1:0]  held [2];
    logic [1:0]         counts;
    logic [1:0]         is_hold;
    logic               is_very_long;
    logic               latch_cleared;
    logic               gest_take;
    keys_t              keys_next;

    assign advance = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign commit = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            hold_reg <= HOLD_RESET;
            very_long_reg <= VERY_LONG_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DEBOUNCE)
            begin
                debounce_reg <= cfg_data;
            end
            if (cfg_index == REG_HOLD)
            begin
                hold_reg <= cfg_data;
            end
            if (cfg_index == REG_VERY_LONG)
            begin
                very_long_reg <= cfg_data;
            end
        end
    end

    assign cur_level[BTN_TOP] = in_item_reg.top_level;
    assign cur_level[BTN_BOTTOM] = in_item_reg.bottom_level;

    // Edge detect and hold measurement, one lane per button
    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            press_time_next[b] = press_time_reg[b];
            if (level_reg[b] && !cur_level[b])
            begin
                press_time_next[b] = in_item_reg.now_ms;
            end
            released[b] = !level_reg[b] && cur_level[b];
            held[b] = in_item_reg.now_ms - press_time_reg[b];
            counts[b] = released[b] && (held[b] > {{(TIME_W-LIMIT_W){1'b0}}, debounce_reg});
            is_hold[b] = held[b] >= {{(TIME_W-LIMIT_W){1'b0}}, hold_reg};
        end
        level_next = cur_level;
        is_very_long = held[BTN_BOTTOM] >= {{(TIME_W-LIMIT_W){1'b0}}, very_long_reg};
    end

    // Gesture latch and key merge
    always_comb
    begin
        latch_cleared = latch_reg;
        if (in_item_reg.touch_ok && in_item_reg.finger_count == '0
            && in_item_reg.gesture_code == GEST_NONE)
        begin
            latch_cleared = 1'b0;
        end
        gest_take = in_item_reg.touch_ok && in_item_reg.gesture_code != GEST_NONE
                    && !latch_cleared;
        latch_next = latch_cleared || gest_take;

        keys_next.key_up = (gest_take && in_item_reg.gesture_code == GEST_UP)
                           || (counts[BTN_TOP] && !is_hold[BTN_TOP]);
        keys_next.key_select = (gest_take && in_item_reg.gesture_code == GEST_TAP)
                               || (counts[BTN_TOP] && is_hold[BTN_TOP]);
        keys_next.key_down = (gest_take && in_item_reg.gesture_code == GEST_DOWN)
                             || (counts[BTN_BOTTOM] && !is_very_long && !is_hold[BTN_BOTTOM]);
        keys_next.key_back = (gest_take && in_item_reg.gesture_code == GEST_RIGHT)
                             || (counts[BTN_BOTTOM] && !is_very_long && is_hold[BTN_BOTTOM]);
        keys_next.power_off = counts[BTN_BOTTOM] && is_very_long;
        keys_next.any_change = keys_next.key_up || keys_next.key_down
                               || keys_next.key_select || keys_next.key_back
                               || keys_next.power_off;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            level_reg <= 2'b11;
            press_time_reg[BTN_TOP] <= '0;
            press_time_reg[BTN_BOTTOM] <= '0;
            latch_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            // Advance the button and gesture state only as a poll moves to the output
            if (commit)
            begin
                level_reg <= level_next;
                press_time_reg[BTN_TOP] <= press_time_next[BTN_TOP];
                press_time_reg[BTN_BOTTOM] <= press_time_next[BTN_BOTTOM];
                latch_reg <= latch_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.now_ms <= s_axis_tdata[31:0];
            in_item_reg.top_level <= s_axis_tdata[32];
            in_item_reg.bottom_level <= s_axis_tdata[33];
            in_item_reg.gesture_code <= s_axis_tdata[41:34];
            in_item_reg.finger_count <= s_axis_tdata[49:42];
            in_item_reg.touch_ok <= s_axis_tuser;
        end
        if (commit)
        begin
            out_keys_reg <= keys_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {{(OUT_DATA_W-$bits(keys_t)){1'b0}}, out_keys_reg};

endmodule

[sv/tbthc_checker.sv]
// Port-level checker for the two-button tap/hold classifier, with its bind.
module tbthc_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [tbthc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import tbthc_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_any_change: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[NUM_KEYS] == (|m_axis_tdata[NUM_KEYS-1:0]))
        else $error("any_change disagrees with key flags");

    // Touch, top and bottom each give at most one key; padding stays zero
    a_key_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $countones(m_axis_tdata[NUM_KEYS-1:0]) <= 3
                          && m_axis_tdata[OUT_DATA_W-1:NUM_KEYS+1] == '0)
        else $error("too many key flags in one result");

    // No result in the first cycle after reset is released
    a_first_out: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_axis_tvalid)
        else $error("result appeared before any transaction");

    // No result without an earlier input transaction when the output was free
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2)
                                 || $past(!s_axis_tready, 1))
        else $error("result without a matching transaction");

endmodule

bind two_button_tap_hold_classifier tbthc_checker u_tbthc_checker (.*);

[dv/two_button_tap_hold_classifier_test.sv]
// Self-checking stream testbench for the two-button tap/hold key classifier.
`timescale 1ns / 100ps

module two_button_tap_hold_classifier_test;
    import tbthc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [CODE_W-1:0] GEST_ODD = 8'h03;

    // Expected key flags per accepted poll, from a private copy of the classifier state
    class key_scoreboard;
        logic [LIMIT_W-1:0] debounce_ms;
        logic [LIMIT_W-1:0] hold_ms;
        logic [LIMIT_W-1:0] very_long_ms;
        logic               level_q [2];
        logic [TIME_W-1:0]  press_ms [2];
        logic               gesture_held;
        keys_t              keys_q [$];
        int unsigned        results_seen;
        int unsigned        errors;
        string              key_names [NUM_KEYS+1] =
            '{"key_up", "key_down", "key_select", "key_back", "power_off", "any_change"};

        function new();
            debounce_ms = DEBOUNCE_RESET;
            hold_ms = HOLD_RESET;
            very_long_ms = VERY_LONG_RESET;
            level_q = '{1'b1, 1'b1};
            press_ms = '{'0, '0};
            gesture_held = 1'b0;
            results_seen = 0;
            errors = 0;
        endfunction

        function void set_limit(logic [CFG_INDEX_W-1:0] idx, logic [LIMIT_W-1:0] value);
            case (idx)
                REG_DEBOUNCE:  debounce_ms = value;
                REG_HOLD:      hold_ms = value;
                REG_VERY_LONG: very_long_ms = value;
                default: ;
            endcase
        endfunction

        // Track the edge; return the hold time on a release that clears the debounce limit
        function logic [TIME_W-1:0] release_hold(int btn, logic lvl, logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] held;
            logic [TIME_W-1:0] span;
            held = '0;
            if (level_q[btn] && !lvl)
                press_ms[btn] = now;
            else if (!level_q[btn] && lvl)
            begin
                span = now - press_ms[btn];
                if (span > TIME_W'(debounce_ms))
                    held = span;
            end
            level_q[btn] = lvl;
            return held;
        endfunction

        function void note_poll(poll_t p);
            keys_t k;
            logic [TIME_W-1:0] held;
            k = '0;
            if (p.touch_ok)
            begin
                if (p.finger_count == 0 && p.gesture_code == GEST_NONE)
                    gesture_held = 1'b0;
                if (p.gesture_code != GEST_NONE && !gesture_held)
                begin
                    gesture_held = 1'b1;
                    case (p.gesture_code)
                        GEST_UP:    k.key_up = 1'b1;
                        GEST_DOWN:  k.key_down = 1'b1;
                        GEST_RIGHT: k.key_back = 1'b1;
                        GEST_TAP:   k.key_select = 1'b1;
                        default: ;
                    endcase
                end
            end
            held = release_hold(BTN_TOP, p.top_level, p.now_ms);
            if (held != 0)
            begin
                if (held >= TIME_W'(hold_ms))
                    k.key_select = 1'b1;
                else
                    k.key_up = 1'b1;
            end
            held = release_hold(BTN_BOTTOM, p.bottom_level, p.now_ms);
            if (held != 0)
            begin
                if (held >= TIME_W'(very_long_ms))
                    k.power_off = 1'b1;
                else if (held >= TIME_W'(hold_ms))
                    k.key_back = 1'b1;
                else
                    k.key_down = 1'b1;
            end
            k.any_change = k.key_up | k.key_down | k.key_select | k.key_back | k.power_off;
            keys_q.insert(keys_q.size(), k);
        endfunction

        function int pending();
            return keys_q.size();
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_keys(logic [OUT_DATA_W-1:0] data);
            keys_t want;
            keys_t got;
            results_seen++;
            if (keys_q.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with no poll pending", results_seen));
                return;
            end
            want = keys_q.pop_front();
            got = keys_t'(data[NUM_KEYS:0]);
            for (int i = 0; i <= NUM_KEYS; i++)
                if (got[i] !== want[i])
                    report_mismatch($sformatf("result %0d %s: got %b, want %b",
                        results_seen, key_names[i], got[i], want[i]));
            if (data[OUT_DATA_W-1:NUM_KEYS+1] !== '0)
                report_mismatch($sformatf("result %0d pad bits %b", results_seen,
                    data[OUT_DATA_W-1:NUM_KEYS+1]));
        endtask

        task flush_leftover();
            while (keys_q.size() != 0)
            begin
                void'(keys_q.pop_front());
                report_mismatch("expected result never arrived");
            end
        endtask
    endclass

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_DEBOUNCE;
    logic [LIMIT_W-1:0]     cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    key_scoreboard sb = new();

    int unsigned       gap_pct = 0;
    int unsigned       stall_pct = 0;
    logic              gen_level [2] = '{1'b1, 1'b1};
    logic [TIME_W-1:0] gen_press [2] = '{'0, '0};
    logic [TIME_W-1:0] gen_now = '0;
    logic [CODE_W-1:0] known_codes [4] = '{GEST_UP, GEST_DOWN, GEST_RIGHT, GEST_TAP};

    two_button_tap_hold_classifier u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("[two_button_tap_hold_classifier] ERROR");
        $finish;
    end

    // Check each result transaction, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_keys(m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic poll_t poll_of(logic [TIME_W-1:0] now, logic top, logic bot,
                                      logic tok, logic [CODE_W-1:0] gest,
                                      logic [CODE_W-1:0] fing);
        poll_t p;
        p.now_ms = now;
        p.top_level = top;
        p.bottom_level = bot;
        p.touch_ok = tok;
        p.gesture_code = gest;
        p.finger_count = fing;
        return p;
    endfunction

    // Hold times clustered around the current limits, with some spread and wild values
    function automatic logic [TIME_W-1:0] pick_hold();
        logic [TIME_W-1:0] nudge;
        nudge = TIME_W'($urandom_range(0, 2)) - 1;
        case ($urandom_range(0, 9))
            0: return TIME_W'(sb.debounce_ms) + nudge;
            1: return TIME_W'(sb.hold_ms) + nudge;
            2: return TIME_W'(sb.very_long_ms) + nudge;
            3: return TIME_W'($urandom_range(0, 80));
            4: return $urandom();
            default: return TIME_W'($urandom_range(0, 4000));
        endcase
    endfunction

    function automatic poll_t next_poll();
        poll_t p;
        logic  rel [2];
        for (int b = 0; b < 2; b++)
            rel[b] = !gen_level[b] && ($urandom_range(0, 99) < 35);
        if (rel[BTN_TOP])
            gen_now = gen_press[BTN_TOP] + pick_hold();
        else if (rel[BTN_BOTTOM])
            gen_now = gen_press[BTN_BOTTOM] + pick_hold();
        else if ($urandom_range(0, 31) == 0)
            gen_now = $urandom();
        else
            gen_now = gen_now + TIME_W'($urandom_range(0, 60));
        for (int b = 0; b < 2; b++)
        begin
            if (rel[b])
                gen_level[b] = 1'b1;
            else if (gen_level[b] && $urandom_range(0, 99) < 30)
            begin
                gen_level[b] = 1'b0;
                gen_press[b] = gen_now;
            end
        end
        p.now_ms = gen_now;
        p.top_level = gen_level[BTN_TOP];
        p.bottom_level = gen_level[BTN_BOTTOM];
        p.touch_ok = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
            0, 1:
            begin
                p.gesture_code = GEST_NONE;
                p.finger_count = '0;
            end
            2, 3, 4, 5:
            begin
                p.gesture_code = known_codes[$urandom_range(0, 3)];
                p.finger_count = CODE_W'($urandom_range(1, 5));
            end
            6:
            begin
                p.gesture_code = GEST_NONE;
                p.finger_count = CODE_W'($urandom_range(1, 255));
            end
            7:
            begin
                p.gesture_code = CODE_W'($urandom());
                p.finger_count = CODE_W'($urandom());
            end
            default:
            begin
                p.gesture_code = $urandom_range(0, 1) ? GEST_ODD
                                                      : CODE_W'($urandom_range(6, 255));
                p.finger_count = CODE_W'($urandom_range(0, 2));
            end
        endcase
        return p;
    endfunction

    task automatic send_poll(input poll_t p);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, p.finger_count, p.gesture_code, p.bottom_level,
                          p.top_level, p.now_ms};
        s_axis_tuser  <= p.touch_ok;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_poll(p);
    endtask

    // Hold the input side until every pending result is out, then let the pipe settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [LIMIT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.set_limit(idx, value);
        @(posedge clk);
    endtask

    task automatic set_limits(input logic [LIMIT_W-1:0] deb, input logic [LIMIT_W-1:0] hold_v,
                              input logic [LIMIT_W-1:0] vlong, input bit poke_spare);
        put_reg(REG_DEBOUNCE, deb);
        put_reg(REG_HOLD, hold_v);
        put_reg(REG_VERY_LONG, vlong);
        if (poke_spare)
            put_reg(REG_SPARE, LIMIT_W'($urandom()));
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // touch path: invalid sample, latch, release, unknown code
        send_poll(poll_of(32'd0, 1'b1, 1'b1, 1'b0, 8'hFF, 8'hFF));
        send_poll(poll_of(32'd1, 1'b1, 1'b1, 1'b1, GEST_UP, 8'd1));
        send_poll(poll_of(32'd2, 1'b1, 1'b1, 1'b1, GEST_UP, 8'd1));
        send_poll(poll_of(32'd3, 1'b1, 1'b1, 1'b1, GEST_NONE, 8'd0));
        send_poll(poll_of(32'd4, 1'b1, 1'b1, 1'b1, GEST_DOWN, 8'd2));
        send_poll(poll_of(32'd5, 1'b1, 1'b1, 1'b1, GEST_NONE, 8'd0));
        send_poll(poll_of(32'd6, 1'b1, 1'b1, 1'b1, GEST_RIGHT, 8'd1));
        send_poll(poll_of(32'd7, 1'b1, 1'b1, 1'b0, GEST_NONE, 8'd0));
        send_poll(poll_of(32'd8, 1'b1, 1'b1, 1'b1, GEST_TAP, 8'd1));
        send_poll(poll_of(32'd9, 1'b1, 1'b1, 1'b1, GEST_NONE, 8'd3));
        send_poll(poll_of(32'd10, 1'b1, 1'b1, 1'b1, GEST_NONE, 8'd0));
        send_poll(poll_of(32'd11, 1'b1, 1'b1, 1'b1, GEST_ODD, 8'd1));
        send_poll(poll_of(32'd12, 1'b1, 1'b1, 1'b1, GEST_TAP, 8'd1));
        send_poll(poll_of(32'd13, 1'b1, 1'b1, 1'b1, GEST_NONE, 8'd0));
        // buttons: bounce at the limit, tap, hold, both at once, wrap-around, all-ones time
        send_poll(poll_of(32'd100, 1'b0, 1'b1, 1'b1, GEST_TAP, 8'd1));
        send_poll(poll_of(32'd125, 1'b1, 1'b1, 1'b0, GEST_NONE, 8'd0));
        send_poll(poll_of(32'd200, 1'b0, 1'b1, 1'b0, GEST_NONE, 8'd0));
        send_poll(poll_of(32'd226, 1'b1, 1'b1, 1'b0, GEST_NONE, 8'd0));
        send_poll(poll_of(32'd300, 1'b0, 1'b0, 1'b0, GEST_NONE, 8'd0));
        send_poll(poll_of(32'd800, 1'b1, 1'b1, 1'b0, GEST_NONE, 8'd0));
        send_poll(poll_of(32'hFFFF_FF00, 1'b1, 1'b0, 1'b0, GEST_NONE, 8'd0));
        send_poll(poll_of(32'h0000_0AB8, 1'b1, 1'b1, 1'b0, GEST_NONE, 8'd0));
        send_poll(poll_of(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, GEST_NONE, 8'd0));
        send_poll(poll_of(32'h0000_01F2, 1'b1, 1'b1, 1'b1, GEST_UP, 8'h80));
        drain_results();

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: set_limits(16'd0, 16'd0, 16'd0, 1'b0);
                1: set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
                2: set_limits(16'd10, 16'd3000, 16'd500, 1'b1);
                3: set_limits(16'd3, 16'd40, 16'd90, 1'b0);
                4: set_limits(LIMIT_W'($urandom_range(0, 200)),
                              LIMIT_W'($urandom_range(0, 2000)),
                              LIMIT_W'($urandom_range(0, 5000)), 1'b1);
                5: set_limits(16'd1000, 16'd60000, 16'hFFFF, 1'b0);
                default: set_limits(DEBOUNCE_RESET, HOLD_RESET, VERY_LONG_RESET, 1'b0);
            endcase
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct <= 0;  end
                1: begin gap_pct = 49; stall_pct <= 0;  end
                2: begin gap_pct = 0;  stall_pct <= 49; end
                default: begin gap_pct = 34; stall_pct <= 34; end
            endcase
            for (int n = 0; n < 256; n++)
            begin
                if (n == 128 && phase % 2 == 1)
                    drain_results();
                send_poll(next_poll());
            end
            drain_results();
        end

        repeat (6) @(posedge clk);
        sb.flush_leftover();
        if (sb.errors == 0)
            $display("[two_button_tap_hold_classifier] OK");
        else
            $display("[two_button_tap_hold_classifier] ERROR");
        $finish;
    end

endmodule

[files.f]
sv/tbthc_pkg.sv
sv/two_button_tap_hold_classifier.sv
sv/tbthc_checker.sv
dv/two_button_tap_hold_classifier_test.sv
